// ----- hw/rtl/bsm_pkg.sv -----
// Shared types, codes and constants of the breakpoint and step manager.
// No dependencies; every other file of the block but bsm_ram imports this package.
package bsm_pkg;

  // Field widths
  localparam int DATA_W  = 32;
  localparam int KIND_W  = 3;
  localparam int INDEX_W = 4;
  localparam int ACT_W   = 2;
  localparam int SLOT_W  = 5;
  localparam int STAT_W  = 3;
  localparam int RES_MAX = 3;

  // Configuration port
  localparam int CFG_AW = 3;
  localparam logic [DATA_W-1:0] MATCH_MASK_RST = 32'h0FFF_FFFF;

  // Default table size
  localparam int BREAK_SLOTS_DEF = 16;

  // Step slot numbers on the slot field
  localparam logic [SLOT_W-1:0] SLOT_STEP0 = 5'd16;
  localparam logic [SLOT_W-1:0] SLOT_STEP1 = 5'd17;

  // Instruction decode codes
  localparam logic [5:0] OP_SPECIAL = 6'h00;
  localparam logic [5:0] OP_REGIMM  = 6'h01;
  localparam logic [5:0] OP_J       = 6'h02;
  localparam logic [5:0] OP_JAL     = 6'h03;
  localparam logic [5:0] OP_BEQ     = 6'h04;
  localparam logic [5:0] OP_BGTZ    = 6'h07;
  localparam logic [5:0] OP_COP0    = 6'h10;
  localparam logic [5:0] OP_COP1    = 6'h11;
  localparam logic [5:0] OP_COP2    = 6'h12;
  localparam logic [5:0] OP_BEQL    = 6'h14;
  localparam logic [5:0] OP_BGTZL   = 6'h17;
  localparam logic [5:0] FN_JR      = 6'h08;
  localparam logic [5:0] FN_JALR    = 6'h09;
  localparam logic [4:0] RT_BLTZ    = 5'h00;
  localparam logic [4:0] RT_BGEZL   = 5'h03;
  localparam logic [4:0] RT_BLTZAL  = 5'h10;
  localparam logic [4:0] RT_BGEZALL = 5'h13;
  localparam logic [9:0] COP_BC_LO  = 10'h100;
  localparam logic [9:0] COP_BC_HI  = 10'h103;

  typedef enum logic [KIND_W-1:0] {
    KIND_SET  = 3'd0,
    KIND_DEL  = 3'd1,
    KIND_STEP = 3'd2,
    KIND_CHK  = 3'd3,
    KIND_EXC  = 3'd4
  } kind_t;

  typedef enum logic [ACT_W-1:0] {
    ACT_NONE    = 2'd0,
    ACT_INSERT  = 2'd1,
    ACT_RESTORE = 2'd2
  } action_t;

  typedef enum logic [STAT_W-1:0] {
    ST_DONE    = 3'd0,
    ST_ALREADY = 3'd1,
    ST_FULL    = 3'd2,
    ST_HIT     = 3'd3,
    ST_NOMATCH = 3'd4
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_READ,
    S_BUILD,
    S_EMIT
  } state_t;

  typedef struct packed {
    action_t             action;
    logic [DATA_W-1:0]   addr;
    logic [SLOT_W-1:0]   slot;
    status_t             status;
  } res_t;

  // Controller to datapath
  typedef struct packed {
    logic load;
    logic scan;
    logic build;
    logic emit;
  } ctl_cmd_t;

  // Datapath to controller
  typedef struct packed {
    kind_t kind;
    logic  scan_done;
    logic  out_free;
    logic  res_last;
  } dp_sts_t;

endpackage

// ----- hw/rtl/bsm_ram.sv -----
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module bsm_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // Write and registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

// ----- hw/rtl/bsm_ctrl.sv -----
// Sequencing state machine of the breakpoint and step manager.
// Depends on bsm_pkg; drives commands to bsm_dpath and reads its status.
module bsm_ctrl (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  input  logic [bsm_pkg::KIND_W-1:0]      in_kind,
  output logic                            in_stall,
  input  bsm_pkg::dp_sts_t                sts,
  output bsm_pkg::ctl_cmd_t               cmd
);
  import bsm_pkg::*;

  state_t state_r;
  state_t state_nxt;

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          case (kind_t'(in_kind))
            KIND_SET, KIND_CHK, KIND_EXC: state_nxt = S_SCAN;
            KIND_DEL:                     state_nxt = S_READ;
            KIND_STEP:                    state_nxt = S_BUILD;
            default:                      state_nxt = S_IDLE;
          endcase
        end
      end
      S_SCAN: begin
        if (sts.scan_done) begin
          state_nxt = S_BUILD;
        end
      end
      S_READ:  state_nxt = S_BUILD;
      S_BUILD: state_nxt = S_EMIT;
      S_EMIT: begin
        if (sts.out_free && sts.res_last) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // Outputs
  always_comb begin
    cmd      = '0;
    in_stall = 1'b1;
    case (state_r)
      S_IDLE: begin
        in_stall = 1'b0;
        cmd.load = in_valid;
      end
      S_SCAN:  cmd.scan  = 1'b1;
      S_READ:  cmd       = '0;
      S_BUILD: cmd.build = 1'b1;
      S_EMIT:  cmd.emit  = sts.out_free;
      default: cmd       = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

// ----- hw/rtl/bsm_dpath.sv -----
// Datapath: request latch, table scan, step decode, result queue, output register.
// Depends on bsm_pkg and bsm_ram; driven by commands from bsm_ctrl.
module bsm_dpath #(
  parameter int BREAK_SLOTS = bsm_pkg::BREAK_SLOTS_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  bsm_pkg::ctl_cmd_t               cmd,
  output bsm_pkg::dp_sts_t                sts,
  input  logic [bsm_pkg::DATA_W-1:0]      match_mask,
  input  logic [bsm_pkg::KIND_W-1:0]      in_kind,
  input  logic [bsm_pkg::DATA_W-1:0]      in_address,
  input  logic [bsm_pkg::INDEX_W-1:0]     in_index,
  input  logic [bsm_pkg::DATA_W-1:0]      in_instruction,
  input  logic [bsm_pkg::DATA_W-1:0]      in_rs_value,
  input  logic                            in_skip,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic [bsm_pkg::ACT_W-1:0]       out_action,
  output logic [bsm_pkg::DATA_W-1:0]      out_target_address,
  output logic [bsm_pkg::SLOT_W-1:0]      out_slot,
  output logic [bsm_pkg::STAT_W-1:0]      out_status,
  output logic                            out_last
);
  import bsm_pkg::*;

  localparam int IW = (BREAK_SLOTS > 1) ? $clog2(BREAK_SLOTS) : 1;
  localparam int CW = $clog2(BREAK_SLOTS + 1);

  // Latched request
  kind_t               kind_r;
  logic [DATA_W-1:0]   addr_r;
  logic [INDEX_W-1:0]  index_r;
  logic [DATA_W-1:0]   insn_r;
  logic [DATA_W-1:0]   rsv_r;
  logic                skip_r;

  // Breakpoint state
  logic [BREAK_SLOTS-1:0] vld_r, vld_nxt;
  logic [1:0]             sv_r, sv_nxt;
  logic [DATA_W-1:0]      saddr_r [2];
  logic [DATA_W-1:0]      saddr_nxt [2];

  // Scan state
  logic [CW-1:0]       scan_cnt_r;
  logic                pend_r;
  logic [IW-1:0]       cmp_idx_r;
  logic                um_found_r;
  logic [IW-1:0]       um_idx_r;
  logic [DATA_W-1:0]   um_addr_r;
  logic                free_found_r;
  logic [IW-1:0]       free_idx_r;
  logic                scan_more;
  logic                ent_match;

  // Result queue and output register
  res_t                res_r [RES_MAX];
  res_t                res_b [RES_MAX];
  logic [1:0]          n_r, n_b;
  logic [1:0]          ptr_r;
  logic                out_valid_r;
  res_t                out_r;
  logic                out_last_r;

  // Table memory
  logic                ram_we;
  logic [IW-1:0]       ram_raddr;
  logic [DATA_W-1:0]   ram_rdata;
  logic [IW-1:0]       idx_w;
  logic                idx_in_range;

  // Step decode
  logic [5:0]          op;
  logic [4:0]          rt;
  logic [9:0]          cop_sub;
  logic [DATA_W-1:0]   pc4, pc8, br_tgt, step_tgt;
  logic                is_br, is_cond, is_link;
  logic                h0, h1;

  assign idx_w        = IW'(index_r);
  assign idx_in_range = int'(index_r) < BREAK_SLOTS;
  assign scan_more    = scan_cnt_r < CW'(BREAK_SLOTS);
  assign ram_raddr    = (kind_r == KIND_DEL) ? idx_w : scan_cnt_r[IW-1:0];
  assign ent_match    = pend_r && vld_r[cmp_idx_r] &&
                        ((ram_rdata & match_mask) == (addr_r & match_mask));

  bsm_ram #(
    .WIDTH (DATA_W),
    .DEPTH (BREAK_SLOTS)
  ) u_tbl (
    .clk   (clk),
    .we    (ram_we),
    .waddr (free_idx_r),
    .wdata (addr_r),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // Decode the instruction at the pc for a step request
  always_comb begin
    op       = insn_r[31:26];
    rt       = insn_r[20:16];
    cop_sub  = insn_r[25:16];
    pc4      = addr_r + 32'd4;
    pc8      = addr_r + 32'd8;
    br_tgt   = pc4 + {{14{insn_r[15]}}, insn_r[15:0], 2'b00};
    step_tgt = pc4;
    is_br    = 1'b0;
    is_cond  = 1'b0;
    is_link  = 1'b0;
    if ((op >= OP_BEQ && op <= OP_BGTZ) || (op >= OP_BEQL && op <= OP_BGTZL)) begin
      is_br    = 1'b1;
      is_cond  = 1'b1;
      step_tgt = br_tgt;
    end else if (op == OP_REGIMM) begin
      if (rt <= RT_BGEZL || (rt >= RT_BLTZAL && rt <= RT_BGEZALL)) begin
        is_br    = 1'b1;
        is_cond  = 1'b1;
        step_tgt = br_tgt;
      end
    end else if (op == OP_J || op == OP_JAL) begin
      is_br    = 1'b1;
      is_link  = (op == OP_JAL);
      step_tgt = {pc4[31:28], insn_r[25:0], 2'b00};
    end else if (op == OP_SPECIAL) begin
      if (insn_r[5:0] == FN_JR || insn_r[5:0] == FN_JALR) begin
        is_br    = 1'b1;
        is_link  = (insn_r[5:0] == FN_JALR);
        step_tgt = rsv_r;
      end
    end else if (op == OP_COP0 || op == OP_COP1 || op == OP_COP2) begin
      if (cop_sub >= COP_BC_LO && cop_sub <= COP_BC_HI) begin
        is_br    = 1'b1;
        is_cond  = 1'b1;
        step_tgt = br_tgt;
      end
    end
  end

  // Assemble the results of the request and the state it leaves behind
  always_comb begin
    res_b[0]     = '0;
    res_b[1]     = '0;
    res_b[2]     = '0;
    n_b          = 2'd1;
    vld_nxt      = vld_r;
    sv_nxt       = sv_r;
    saddr_nxt[0] = saddr_r[0];
    saddr_nxt[1] = saddr_r[1];
    ram_we       = 1'b0;
    h0           = sv_r[0] && (saddr_r[0] == addr_r);
    h1           = sv_r[1] && (saddr_r[1] == addr_r);
    case (kind_r)
      KIND_SET: begin
        if (um_found_r) begin
          res_b[0] = '{ACT_NONE, '0, SLOT_W'(um_idx_r), ST_ALREADY};
        end else if (free_found_r) begin
          res_b[0] = '{ACT_INSERT, addr_r, SLOT_W'(free_idx_r), ST_DONE};
          vld_nxt[free_idx_r] = 1'b1;
          ram_we   = cmd.build;
        end else begin
          res_b[0] = '{ACT_NONE, '0, '0, ST_FULL};
        end
      end
      KIND_DEL: begin
        if (idx_in_range && vld_r[idx_w]) begin
          res_b[0] = '{ACT_RESTORE, ram_rdata, SLOT_W'(index_r), ST_DONE};
          vld_nxt[idx_w] = 1'b0;
        end else begin
          res_b[0] = '{ACT_NONE, '0, SLOT_W'(index_r), ST_DONE};
        end
      end
      KIND_STEP: begin
        if (is_link && skip_r) begin
          res_b[0]     = '{ACT_INSERT, pc8, SLOT_STEP1, ST_DONE};
          sv_nxt[1]    = 1'b1;
          saddr_nxt[1] = pc8;
        end else begin
          res_b[0]     = '{ACT_INSERT, step_tgt, SLOT_STEP0, ST_DONE};
          sv_nxt[0]    = 1'b1;
          saddr_nxt[0] = step_tgt;
          if (is_br && is_cond && step_tgt != pc8) begin
            res_b[1]     = '{ACT_INSERT, pc8, SLOT_STEP1, ST_DONE};
            n_b          = 2'd2;
            sv_nxt[1]    = 1'b1;
            saddr_nxt[1] = pc8;
          end
        end
      end
      KIND_CHK: begin
        if (h0) begin
          res_b[0] = '{ACT_NONE, '0, SLOT_STEP0, ST_HIT};
        end else if (h1) begin
          res_b[0] = '{ACT_NONE, '0, SLOT_STEP1, ST_HIT};
        end else if (um_found_r) begin
          res_b[0] = '{ACT_NONE, '0, SLOT_W'(um_idx_r), ST_HIT};
        end else begin
          res_b[0] = '{ACT_NONE, '0, '0, ST_NOMATCH};
        end
      end
      KIND_EXC: begin
        if (h0 || h1 || um_found_r) begin
          // Restore step slots first, then the one-shot user slot
          n_b = 2'd0;
          if (sv_r[0]) begin
            res_b[n_b] = '{ACT_RESTORE, saddr_r[0], SLOT_STEP0, ST_HIT};
            n_b        = n_b + 2'd1;
          end
          if (sv_r[1]) begin
            res_b[n_b] = '{ACT_RESTORE, saddr_r[1], SLOT_STEP1, ST_HIT};
            n_b        = n_b + 2'd1;
          end
          if (um_found_r) begin
            res_b[n_b] = '{ACT_RESTORE, um_addr_r, SLOT_W'(um_idx_r), ST_HIT};
            n_b        = n_b + 2'd1;
            vld_nxt[um_idx_r] = 1'b0;
          end
          sv_nxt = 2'b00;
        end else begin
          res_b[0] = '{ACT_NONE, '0, '0, ST_NOMATCH};
        end
      end
      default: n_b = 2'd1;
    endcase
  end

  // Latch the request and hold it for the whole operation
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      kind_r  <= kind_t'(in_kind);
      addr_r  <= in_address;
      index_r <= in_index;
      insn_r  <= in_instruction;
      rsv_r   <= in_rs_value;
      skip_r  <= in_skip;
    end
  end

  // Scan the table one entry a cycle, comparing each entry in the cycle after its memory read
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      scan_cnt_r   <= '0;
      pend_r       <= 1'b0;
      um_found_r   <= 1'b0;
      free_found_r <= 1'b0;
    end else if (cmd.scan) begin
      pend_r    <= scan_more;
      cmp_idx_r <= scan_cnt_r[IW-1:0];
      if (scan_more) begin
        scan_cnt_r <= scan_cnt_r + CW'(1);
      end
      if (ent_match && !um_found_r) begin
        um_found_r <= 1'b1;
        um_idx_r   <= cmp_idx_r;
        um_addr_r  <= ram_rdata;
      end
      if (pend_r && !vld_r[cmp_idx_r] && !free_found_r) begin
        free_found_r <= 1'b1;
        free_idx_r   <= cmp_idx_r;
      end
    end
  end

  // Commit state and capture the results
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
      sv_r  <= '0;
    end else if (cmd.build) begin
      vld_r <= vld_nxt;
      sv_r  <= sv_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.build) begin
      saddr_r[0] <= saddr_nxt[0];
      saddr_r[1] <= saddr_nxt[1];
      res_r[0]   <= res_b[0];
      res_r[1]   <= res_b[1];
      res_r[2]   <= res_b[2];
      n_r        <= n_b;
    end
  end

  // Advance the result pointer and load the output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      ptr_r       <= '0;
    end else begin
      if (cmd.build) begin
        ptr_r <= '0;
      end else if (cmd.emit) begin
        ptr_r <= ptr_r + 2'd1;
      end
      if (cmd.emit) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_r      <= res_r[ptr_r];
      out_last_r <= sts.res_last;
    end
  end

  assign sts.kind      = kind_r;
  assign sts.scan_done = !scan_more && !pend_r;
  assign sts.out_free  = !out_valid_r || !out_stall;
  assign sts.res_last  = (ptr_r == n_r - 2'd1);

  assign out_valid          = out_valid_r;
  assign out_action         = out_r.action;
  assign out_target_address = out_r.addr;
  assign out_slot           = out_r.slot;
  assign out_status         = out_r.status;
  assign out_last           = out_last_r;

endmodule

// ----- hw/rtl/breakpoint_step_manager.sv -----
// Breakpoint and single-step manager: top level, match mask register, APB port.
// Step requests go straight to result assembly, delete reads one table word first, and set,
// check and exception search the table one memory word per cycle before results are built.
// A new request is taken once the last result (up to 3) is loaded into the output register.
// Reset (synchronous, rst_n low) clears all user and step valid bits and the control
// state and loads the match mask with 0x0FFFFFFF; table addresses are not cleared.
module breakpoint_step_manager #(
  parameter int BREAK_SLOTS = bsm_pkg::BREAK_SLOTS_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  // Request channel
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic [bsm_pkg::KIND_W-1:0]      in_kind,
  input  logic [bsm_pkg::DATA_W-1:0]      in_address,
  input  logic [bsm_pkg::INDEX_W-1:0]     in_index,
  input  logic [bsm_pkg::DATA_W-1:0]      in_instruction,
  input  logic [bsm_pkg::DATA_W-1:0]      in_rs_value,
  input  logic                            in_skip,
  // Result channel
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic [bsm_pkg::ACT_W-1:0]       out_action,
  output logic [bsm_pkg::DATA_W-1:0]      out_target_address,
  output logic [bsm_pkg::SLOT_W-1:0]      out_slot,
  output logic [bsm_pkg::STAT_W-1:0]      out_status,
  output logic                            out_last,
  // Configuration port
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [bsm_pkg::CFG_AW-1:0]      paddr,
  input  logic [bsm_pkg::DATA_W-1:0]      pwdata,
  output logic [bsm_pkg::DATA_W-1:0]      prdata,
  output logic                            pready
);
  import bsm_pkg::*;

  logic [DATA_W-1:0] match_mask_r;
  logic              mask_sel;
  ctl_cmd_t          cmd;
  dp_sts_t           sts;

  // Match mask register at byte address 0
  assign mask_sel = (paddr[CFG_AW-1] == 1'b0);
  assign pready   = 1'b1;
  assign prdata   = mask_sel ? match_mask_r : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      match_mask_r <= MATCH_MASK_RST;
    end else if (psel && penable && pwrite && mask_sel) begin
      match_mask_r <= pwdata;
    end
  end

  bsm_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_kind  (in_kind),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  bsm_dpath #(
    .BREAK_SLOTS (BREAK_SLOTS)
  ) u_dpath (
    .clk                (clk),
    .rst_n              (rst_n),
    .cmd                (cmd),
    .sts                (sts),
    .match_mask         (match_mask_r),
    .in_kind            (in_kind),
    .in_address         (in_address),
    .in_index           (in_index),
    .in_instruction     (in_instruction),
    .in_rs_value        (in_rs_value),
    .in_skip            (in_skip),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_action         (out_action),
    .out_target_address (out_target_address),
    .out_slot           (out_slot),
    .out_status         (out_status),
    .out_last           (out_last)
  );

  // Unknown request kinds are dropped without leaving idle
  a_drop_unknown: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall && (in_kind > KIND_EXC) |=> !in_stall)
    else $error("unknown request kind left the block busy");

  // A known request keeps the request channel stalled in the next cycle
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall && (in_kind <= KIND_EXC) |=> in_stall)
    else $error("request accepted while the previous one is in progress");

  // Only the final result of a request may be shown while idle
  a_last_before_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_last |-> in_stall)
    else $error("block went idle before its last result");

  // Inserts always report success
  a_insert_done: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_action == ACT_INSERT) |-> (out_status == ST_DONE))
    else $error("insert result with a status other than done");

endmodule

// ----- tb/tb_breakpoint_step_manager.sv -----
// Self-checking testbench for breakpoint_step_manager: requests, random idling, mask writes.
// Depends on bsm_pkg for field widths, codes and the reset value of the match mask.
`timescale 1ns / 1ps

module tb_breakpoint_step_manager;
  import bsm_pkg::*;

  localparam int CYCLE_LIMIT = 200000;
  localparam int PHASE_ITEMS = 26;
  localparam int NUM_MASKS = 5;
  localparam logic [CFG_AW-1:0] REG_MATCH_MASK = '0;
  localparam logic [KIND_W-1:0] KIND_UNUSED_HI = 3'd7;

  // One host command as the block reports it
  typedef struct packed {
    action_t           act;
    logic [DATA_W-1:0] addr;
    logic [SLOT_W-1:0] slot;
    status_t           st;
    logic              last;
  } host_cmd_t;

  // Breakpoint table shadow and queue of host commands still owed by the block
  class bkpt_tracker;
    logic [DATA_W-1:0] mask;
    logic [DATA_W-1:0] user_addr [BREAK_SLOTS_DEF];
    bit                user_used [BREAK_SLOTS_DEF];
    logic [DATA_W-1:0] step_addr [2];
    bit                step_used [2];
    host_cmd_t         cmds [$];
    int                mismatches;
    int                accepted;
    int                checked;

    function new();
      mask = MATCH_MASK_RST;
      foreach (user_used[i]) begin
        user_used[i] = 1'b0;
        user_addr[i] = '0;
      end
      foreach (step_used[i]) begin
        step_used[i] = 1'b0;
        step_addr[i] = '0;
      end
      mismatches = 0;
      accepted = 0;
      checked = 0;
    endfunction

    function void report(string msg);
      mismatches++;
      $display("mismatch: %s", msg);
    endfunction

    function void add_cmd(action_t a, logic [DATA_W-1:0] ad, logic [SLOT_W-1:0] s, status_t st);
      host_cmd_t c;
      c.act = a;
      c.addr = ad;
      c.slot = s;
      c.st = st;
      c.last = 1'b0;
      cmds.push_back(c);
    endfunction

    // First valid user slot whose masked address matches, or -1
    function int find_user(logic [DATA_W-1:0] a);
      for (int i = 0; i < BREAK_SLOTS_DEF; i++)
        if (user_used[i] && ((user_addr[i] & mask) == (a & mask))) return i;
      return -1;
    endfunction

    function logic [DATA_W-1:0] rel_target(logic [DATA_W-1:0] pc, logic [DATA_W-1:0] insn);
      return pc + 32'd4 + {{14{insn[15]}}, insn[15:0], 2'b00};
    endfunction

    // Update the shadow table for an accepted request and queue its commands
    function void note_request(logic [KIND_W-1:0] kind, logic [DATA_W-1:0] pc,
                               logic [INDEX_W-1:0] idx, logic [DATA_W-1:0] insn,
                               logic [DATA_W-1:0] rsv, logic skip);
      int um;
      int free_slot;
      int n0;
      logic [DATA_W-1:0] tgt;
      logic [DATA_W-1:0] pc4;
      logic [DATA_W-1:0] pc8;
      logic [5:0] op;
      logic [4:0] rt;
      logic [9:0] sub;
      bit br;
      bit cnd;
      bit lnk;
      bit h0;
      bit h1;
      n0 = cmds.size();
      accepted++;
      case (kind)
        KIND_SET: begin
          um = find_user(pc);
          if (um >= 0) begin
            add_cmd(ACT_NONE, '0, SLOT_W'(um), ST_ALREADY);
          end else begin
            free_slot = -1;
            for (int i = 0; i < BREAK_SLOTS_DEF; i++)
              if (!user_used[i] && free_slot < 0) free_slot = i;
            if (free_slot >= 0) begin
              user_addr[free_slot] = pc;
              user_used[free_slot] = 1'b1;
              add_cmd(ACT_INSERT, pc, SLOT_W'(free_slot), ST_DONE);
            end else begin
              add_cmd(ACT_NONE, '0, '0, ST_FULL);
            end
          end
        end
        KIND_DEL: begin
          if (user_used[idx]) begin
            user_used[idx] = 1'b0;
            add_cmd(ACT_RESTORE, user_addr[idx], SLOT_W'(idx), ST_DONE);
          end else begin
            add_cmd(ACT_NONE, '0, SLOT_W'(idx), ST_DONE);
          end
        end
        KIND_STEP: begin
          op = insn[31:26];
          pc4 = pc + 32'd4;
          pc8 = pc + 32'd8;
          tgt = pc4;
          br = 1'b0;
          cnd = 1'b0;
          lnk = 1'b0;
          // decode branch class and target
          if ((op >= OP_BEQ && op <= OP_BGTZ) || (op >= OP_BEQL && op <= OP_BGTZL)) begin
            br = 1'b1;
            cnd = 1'b1;
            tgt = rel_target(pc, insn);
          end else if (op == OP_REGIMM) begin
            rt = insn[20:16];
            if (rt <= RT_BGEZL || (rt >= RT_BLTZAL && rt <= RT_BGEZALL)) begin
              br = 1'b1;
              cnd = 1'b1;
              tgt = rel_target(pc, insn);
            end
          end else if (op == OP_J || op == OP_JAL) begin
            lnk = (op == OP_JAL);
            br = 1'b1;
            tgt = {pc4[31:28], insn[25:0], 2'b00};
          end else if (op == OP_SPECIAL) begin
            if (insn[5:0] == FN_JR || insn[5:0] == FN_JALR) begin
              lnk = (insn[5:0] == FN_JALR);
              br = 1'b1;
              tgt = rsv;
            end
          end else if (op >= OP_COP0 && op <= OP_COP2) begin
            sub = insn[25:16];
            if (sub >= COP_BC_LO && sub <= COP_BC_HI) begin
              br = 1'b1;
              cnd = 1'b1;
              tgt = rel_target(pc, insn);
            end
          end
          // place step breakpoints
          if (lnk && skip) begin
            step_addr[1] = pc8;
            step_used[1] = 1'b1;
            add_cmd(ACT_INSERT, pc8, SLOT_STEP1, ST_DONE);
          end else begin
            step_addr[0] = tgt;
            step_used[0] = 1'b1;
            add_cmd(ACT_INSERT, tgt, SLOT_STEP0, ST_DONE);
            if (br && cnd && tgt != pc8) begin
              step_addr[1] = pc8;
              step_used[1] = 1'b1;
              add_cmd(ACT_INSERT, pc8, SLOT_STEP1, ST_DONE);
            end
          end
        end
        KIND_CHK, KIND_EXC: begin
          um = find_user(pc);
          h0 = step_used[0] && step_addr[0] == pc;
          h1 = step_used[1] && step_addr[1] == pc;
          if (!(h0 || h1 || um >= 0)) begin
            add_cmd(ACT_NONE, '0, '0, ST_NOMATCH);
          end else if (kind == KIND_CHK) begin
            add_cmd(ACT_NONE, '0, h0 ? SLOT_STEP0 : (h1 ? SLOT_STEP1 : SLOT_W'(um)), ST_HIT);
          end else begin
            // restore the used step slots, then the one-shot user breakpoint
            for (int i = 0; i < 2; i++) begin
              if (step_used[i]) begin
                step_used[i] = 1'b0;
                add_cmd(ACT_RESTORE, step_addr[i], SLOT_STEP0 + SLOT_W'(i), ST_HIT);
              end
            end
            if (um >= 0) begin
              user_used[um] = 1'b0;
              add_cmd(ACT_RESTORE, user_addr[um], SLOT_W'(um), ST_HIT);
            end
          end
        end
        default: ;
      endcase
      if (cmds.size() > n0) cmds[cmds.size()-1].last = 1'b1;
    endfunction

    // Compare one accepted result with the oldest owed command
    function void check_result(logic [ACT_W-1:0] act, logic [DATA_W-1:0] ad,
                               logic [SLOT_W-1:0] s, logic [STAT_W-1:0] st, logic lst);
      host_cmd_t e;
      checked++;
      if (cmds.size() == 0) begin
        report($sformatf("result with nothing owed: action=%0d addr=%h slot=%0d status=%0d",
                         act, ad, s, st));
        return;
      end
      e = cmds.pop_front();
      if (act !== e.act) report($sformatf("action %0d, want %0d", act, e.act));
      if (ad !== e.addr) report($sformatf("target_address %h, want %h", ad, e.addr));
      if (s !== e.slot) report($sformatf("slot %0d, want %0d", s, e.slot));
      if (st !== e.st) report($sformatf("status %0d, want %0d", st, e.st));
      if (lst !== e.last) report($sformatf("last %0b, want %0b", lst, e.last));
    endfunction
  endclass

  logic                 clk;
  logic                 rst_n;
  logic                 in_valid;
  logic                 in_stall;
  logic [KIND_W-1:0]    in_kind;
  logic [DATA_W-1:0]    in_address;
  logic [INDEX_W-1:0]   in_index;
  logic [DATA_W-1:0]    in_instruction;
  logic [DATA_W-1:0]    in_rs_value;
  logic                 in_skip;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  logic [ACT_W-1:0]     out_action;
  logic [DATA_W-1:0]    out_target_address;
  logic [SLOT_W-1:0]    out_slot;
  logic [STAT_W-1:0]    out_status;
  logic                 out_last;
  logic                 psel;
  logic                 penable;
  logic                 pwrite;
  logic [CFG_AW-1:0]    paddr;
  logic [DATA_W-1:0]    pwdata;
  logic [DATA_W-1:0]    prdata;
  logic                 pready;

  bkpt_tracker sb = new();
  bit calm = 1'b0;
  int cycles = 0;
  int stall_run = 0;
  logic [DATA_W-1:0] addr_pool [$];

  breakpoint_step_manager uut (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_kind(in_kind),
    .in_address(in_address),
    .in_index(in_index),
    .in_instruction(in_instruction),
    .in_rs_value(in_rs_value),
    .in_skip(in_skip),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_action(out_action),
    .out_target_address(out_target_address),
    .out_slot(out_slot),
    .out_status(out_status),
    .out_last(out_last),
    .psel(psel),
    .penable(penable),
    .pwrite(pwrite),
    .paddr(paddr),
    .pwdata(pwdata),
    .prdata(prdata),
    .pready(pready)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Watchdog on total run length
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results still owed", cycles, sb.cmds.size());
      $display("TB_ERROR");
      $finish;
    end
  end

  // Sample both handshakes at the rising edge
  always @(posedge clk) begin
    if (rst_n === 1'b1) begin
      if (in_valid === 1'b1 && in_stall === 1'b0)
        sb.note_request(in_kind, in_address, in_index, in_instruction, in_rs_value, in_skip);
      if (out_valid === 1'b1 && out_stall === 1'b0)
        sb.check_result(out_action, out_target_address, out_slot, out_status, out_last);
    end
  end

  // Stall the result side in short bursts and the odd long one
  always @(negedge clk) begin
    if (stall_run > 0) begin
      out_stall <= 1'b1;
      stall_run <= stall_run - 1;
    end else if (!calm && $urandom_range(0, 99) < 25) begin
      out_stall <= 1'b1;
      stall_run <= ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40) : $urandom_range(0, 2);
    end else begin
      out_stall <= 1'b0;
    end
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (calm || r < 50) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 96) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  // Address biased toward live breakpoints so that hits are common
  function automatic logic [DATA_W-1:0] pick_pc();
    int r;
    logic [DATA_W-1:0] base;
    r = $urandom_range(0, 9);
    base = (addr_pool.size() > 0) ? addr_pool[$urandom_range(0, addr_pool.size() - 1)] : $urandom;
    if (r <= 3) return $urandom;
    if (r <= 5) return base;
    if (r == 6) return base ^ {4'($urandom), 28'h0};
    if (r <= 8) return sb.step_addr[$urandom_range(0, 1)];
    case ($urandom_range(0, 2))
      0: return 32'h0000_0000;
      1: return 32'hFFFF_FFFF;
      default: return 32'hFFFF_FFFC;
    endcase
  endfunction

  // Instruction word spread over every decode class
  function automatic logic [DATA_W-1:0] make_insn();
    logic [DATA_W-1:0] w;
    int r;
    w = $urandom;
    r = $urandom_range(0, 9);
    if (r <= 1) begin
      w[31:26] = 6'(($urandom_range(0, 1) ? OP_BEQ : OP_BEQL) + $urandom_range(0, 3));
    end else if (r == 2) begin
      w[31:26] = OP_REGIMM;
    end else if (r == 3) begin
      w[31:26] = 6'(OP_J + $urandom_range(0, 1));
    end else if (r == 4) begin
      w[31:26] = OP_SPECIAL;
      if ($urandom_range(0, 2) != 0) w[5:0] = 6'(FN_JR + $urandom_range(0, 1));
    end else if (r == 5) begin
      w[31:26] = 6'(OP_COP0 + $urandom_range(0, 2));
      if ($urandom_range(0, 1)) w[25:16] = 10'(COP_BC_LO + $urandom_range(0, 3));
    end else if (r == 6) begin
      // branch whose target is the delay slot successor
      w[31:26] = OP_BEQ;
      w[15:0] = 16'h0001;
    end
    return w;
  endfunction

  // Present one request and hold it until accepted
  task automatic send_req(logic [KIND_W-1:0] k, logic [DATA_W-1:0] a, logic [INDEX_W-1:0] ix,
                          logic [DATA_W-1:0] ins, logic [DATA_W-1:0] rv, logic sk);
    int gap;
    gap = pick_gap();
    @(negedge clk);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_kind <= k;
    in_address <= a;
    in_index <= ix;
    in_instruction <= ins;
    in_rs_value <= rv;
    in_skip <= sk;
    in_valid <= 1'b1;
    do @(posedge clk); while (in_stall !== 1'b0);
  endtask

  // Drop valid and wait until every owed result is out, plus the search latency
  task automatic settle_idle();
    @(negedge clk);
    in_valid <= 1'b0;
    while (sb.cmds.size() != 0) @(negedge clk);
    repeat (BREAK_SLOTS_DEF + 10) @(negedge clk);
  endtask

  // Write the match mask, then read it back
  task automatic write_match_mask(logic [DATA_W-1:0] v);
    @(negedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= REG_MATCH_MASK;
    pwdata <= v;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (pready !== 1'b1);
    sb.mask = v;
    @(negedge clk);
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (pready !== 1'b1);
    if (prdata !== v) sb.report($sformatf("match_mask read %h, want %h", prdata, v));
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
  endtask

  initial begin
    logic [DATA_W-1:0] phase_mask [NUM_MASKS];
    logic [DATA_W-1:0] pc;
    logic [DATA_W-1:0] a;
    int n_items;
    int r;
    phase_mask = '{32'hFFFF_FFFF, 32'h0000_0000, 32'h0, MATCH_MASK_RST, 32'hFFFF_FFF0};
    phase_mask[2] = $urandom;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_kind = KIND_SET;
    in_address = '0;
    in_index = '0;
    in_instruction = '0;
    in_rs_value = '0;
    in_skip = 1'b0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed: table extremes, duplicates, delete cases, every step decode class
    send_req(KIND_SET, 32'h0000_0000, 4'd0, '0, '0, 1'b0);
    send_req(KIND_SET, 32'hFFFF_FFFF, 4'd0, '0, '0, 1'b0);
    send_req(KIND_SET, 32'hF000_0000, 4'd0, '0, '0, 1'b0);
    send_req(KIND_CHK, 32'hFFFF_FFFF, 4'd0, '0, '0, 1'b0);
    send_req(KIND_CHK, 32'h1234_5678, 4'd0, '0, '0, 1'b0);
    send_req(KIND_DEL, 32'h0, 4'd1, '0, '0, 1'b0);
    send_req(KIND_DEL, 32'h0, 4'd1, '0, '0, 1'b0);
    send_req(KIND_DEL, 32'h0, 4'd15, '0, '0, 1'b0);
    send_req(KIND_STEP, 32'h8000_0100, 4'd0, {OP_BEQ, 5'd1, 5'd2, 16'h0001}, '0, 1'b0);
    send_req(KIND_STEP, 32'h8000_0200, 4'd0, {OP_BEQ + 6'd1, 5'd3, 5'd4, 16'hFFFF}, '0, 1'b0);
    send_req(KIND_CHK, 32'h8000_0200, 4'd0, '0, '0, 1'b0);
    send_req(KIND_EXC, 32'h8000_0208, 4'd0, '0, '0, 1'b0);
    send_req(KIND_EXC, 32'h8000_0208, 4'd0, '0, '0, 1'b0);
    send_req(KIND_STEP, 32'hFFFF_FFFC, 4'd0, {OP_BEQL, 10'h3FF, 16'h7FFF}, '0, 1'b1);
    send_req(KIND_STEP, 32'h0040_0000, 4'd0, {OP_REGIMM, 5'd5, RT_BLTZAL, 16'h0010}, '0, 1'b1);
    send_req(KIND_STEP, 32'h0040_0100, 4'd0, {OP_REGIMM, 5'd5, 5'h04, 16'h0010}, '0, 1'b0);
    send_req(KIND_STEP, 32'h9FFF_FFFC, 4'd0, {OP_J, 26'h3FF_FFFF}, '0, 1'b0);
    send_req(KIND_STEP, 32'h0040_0200, 4'd0, {OP_JAL, 26'h012_3456}, '0, 1'b1);
    send_req(KIND_STEP, 32'h0040_0200, 4'd0, {OP_JAL, 26'h012_3456}, '0, 1'b0);
    send_req(KIND_STEP, 32'h0040_0300, 4'd0, {OP_SPECIAL, 5'd31, 15'h0, FN_JR},
             32'hDEAD_BEEF, 1'b1);
    send_req(KIND_STEP, 32'h0040_0400, 4'd0, {OP_SPECIAL, 5'd8, 5'd0, 5'd31, 5'd0, FN_JALR},
             32'h0000_1000, 1'b1);
    send_req(KIND_STEP, 32'h0040_0500, 4'd0, {OP_COP1, COP_BC_LO, 16'h8000}, '0, 1'b0);
    send_req(KIND_STEP, 32'h0040_0600, 4'd0, {OP_COP0, 10'h000, 16'h6000}, '0, 1'b0);
    send_req(KIND_STEP, 32'h0000_0000, 4'd0, 32'h0000_0000, '0, 1'b0);
    send_req(KIND_SET, 32'h0000_0004, 4'd0, '0, '0, 1'b0);
    send_req(KIND_EXC, 32'h0000_0004, 4'd0, '0, '0, 1'b0);
    send_req(KIND_UNUSED_HI, 32'hFFFF_FFFF, 4'hF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1);

    // Random phases, one per match mask setting
    for (int p = 0; p < NUM_MASKS; p++) begin
      settle_idle();
      write_match_mask(phase_mask[p]);
      n_items = 0;
      while (n_items < PHASE_ITEMS) begin
        calm = ((n_items / 8) % 4) == 3;
        r = $urandom_range(0, 9);
        if (r <= 3) begin
          // single step, then maybe stop at pc+8 or at one of the step slots
          pc = pick_pc();
          send_req(KIND_STEP, pc, 4'($urandom), make_insn(),
                   $urandom_range(0, 1) ? pick_pc() : $urandom, 1'($urandom));
          n_items++;
          if ($urandom_range(0, 3) != 0) begin
            a = ($urandom_range(0, 2) == 0) ? pc + 32'd8 : sb.step_addr[$urandom_range(0, 1)];
            send_req($urandom_range(0, 1) ? KIND_EXC : KIND_CHK, a, 4'($urandom), $urandom,
                     $urandom, 1'($urandom));
            n_items++;
          end
        end else if (r <= 5) begin
          // set a breakpoint, then maybe reach it
          pc = pick_pc();
          send_req(KIND_SET, pc, 4'($urandom), $urandom, $urandom, 1'($urandom));
          addr_pool.push_back(pc);
          if (addr_pool.size() > 16) void'(addr_pool.pop_front());
          n_items++;
          if ($urandom_range(0, 1)) begin
            a = ($urandom_range(0, 1)) ? pc : pc ^ {4'($urandom), 28'h0};
            send_req($urandom_range(0, 1) ? KIND_EXC : KIND_CHK, a, 4'($urandom), $urandom,
                     $urandom, 1'($urandom));
            n_items++;
          end
        end else if (r == 6) begin
          send_req(KIND_DEL, $urandom, 4'($urandom), $urandom, $urandom, 1'($urandom));
          n_items++;
        end else if (r <= 8) begin
          send_req(3'($urandom_range(0, 4)), pick_pc(), 4'($urandom), make_insn(), $urandom,
                   1'($urandom));
          n_items++;
        end else begin
          // noise: unused request kinds with random fields
          send_req(3'(KIND_EXC + $urandom_range(1, 3)), $urandom, 4'($urandom), $urandom,
                   $urandom, 1'($urandom));
        end
      end
      calm = 1'b0;
    end

    settle_idle();
    $display("covered %0d requests and %0d results across %0d match mask settings",
             sb.accepted, sb.checked, NUM_MASKS + 1);
    if (sb.mismatches == 0) begin
      $display("TB_OK");
    end else begin
      $display("%0d mismatches", sb.mismatches);
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

// ----- breakpoint_step_manager.f -----
hw/rtl/bsm_pkg.sv
hw/rtl/bsm_ram.sv
hw/rtl/bsm_ctrl.sv
hw/rtl/bsm_dpath.sv
hw/rtl/breakpoint_step_manager.sv
tb/tb_breakpoint_step_manager.sv
